>>> rtl/stereo_chorus_feedback_delay_defines.svh
// assertion macros for the chorus block
`ifndef STEREO_CHORUS_FEEDBACK_DELAY_DEFINES_SVH
`define STEREO_CHORUS_FEEDBACK_DELAY_DEFINES_SVH

// same-cycle implication
`define SCFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfd same-cycle check failed");

// next-cycle implication
`define SCFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfd next-cycle check failed");

`endif

>>> rtl/scfd_pkg.sv
package scfd_pkg;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic [2:0] REG_FEEDBACK = 3'd0;
  localparam logic [2:0] REG_MIX      = 3'd1;
  localparam logic [2:0] REG_DEPTH    = 3'd2;
  localparam logic [2:0] REG_STEP     = 3'd3;
  localparam logic [2:0] REG_OFFSET   = 3'd4;
  localparam logic [2:0] REG_CENTER   = 3'd5;
  localparam logic [2:0] REG_SWING    = 3'd6;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } line_ctl_t;

  // quarter-wave sine entry q of a table with 2**sw entries, q in 0 .. 2**(sw-2)
  function automatic logic [15:0] quarter_entry(input int unsigned q, input int unsigned sw);
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    r  = 64'(q) << (32 - sw);
    a  = (r * HALF_PI_Q30) >> 30;
    a2 = (a * a) >> 30;
    t  = ONE_Q30 - a2 / 64'd110;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    v  = (s * 64'd32767 + 64'd536870912) >> 30;
    return v[15:0];
  endfunction

endpackage

>>> rtl/stereo_chorus_feedback_delay.sv
// Stereo chorus with feedback. One beat on in_ carries a left/right sample pair and
// produces exactly one beat on out_. The block is ready for a new pair on the next clock
// after the previous pair reaches the output register, so pairs never overlap: both
// channels run in turn through a 12-step sequence that shares one signed multiplier
// (lfo depth, swing, two interpolation taps, feedback, dry and wet mix), with the delay
// lines read through a registered two-address port. A pair that finishes while the
// previous beat still waits on out_ holds in its last step until that beat leaves.
// After reset the block clears both delay lines, one entry per clock over all
// BUFFER_DEPTH entries, and holds in_tready low meanwhile; configuration writes are
// taken at any time but must only be issued while no pair is in flight.
`include "stereo_chorus_feedback_delay_defines.svh"
module stereo_chorus_feedback_delay
  import scfd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 2048,
  parameter int SINE_ENTRIES = 1024,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // left_in, right_in
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,
  input  logic                                   cfg_wr_en,
  input  logic [2:0]                             cfg_addr,
  input  logic [24:0]                            cfg_wdata
);

  localparam int SB   = SAMPLE_BITS;
  localparam int TDW  = ((2*SB+7)/8)*8;
  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int DW   = AW + 8;
  localparam int RPW  = DW + 1;
  localparam int SW   = $clog2(SINE_ENTRIES);
  localparam int QN   = SINE_ENTRIES / 4;
  localparam int MA   = ((SB > 19) ? SB : 19) + 1;
  localparam int MB   = 17;
  localparam int PW   = MA + MB;
  localparam int DLW  = 26;
  localparam int SPAN = BUFFER_DEPTH * 256;
  localparam int DHI  = (BUFFER_DEPTH - 2) * 256;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SIN  = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_DLY  = 4'd4;
  localparam logic [3:0] ST_ADDR = 4'd5;
  localparam logic [3:0] ST_I1   = 4'd6;
  localparam logic [3:0] ST_I2   = 4'd7;
  localparam logic [3:0] ST_I3   = 4'd8;
  localparam logic [3:0] ST_FB   = 4'd9;
  localparam logic [3:0] ST_M5   = 4'd10;
  localparam logic [3:0] ST_M6   = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  // config registers
  logic [9:0]  fbg_r;
  logic [10:0] mix_r;
  logic [10:0] depth_r;
  logic [24:0] step_r;
  logic [15:0] offset_r;
  logic [18:0] center_r;
  logic [18:0] swing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbg_r    <= 10'd512;
      mix_r    <= 11'd512;
      depth_r  <= 11'd512;
      step_r   <= 25'd44739;
      offset_r <= 16'd0;
      center_r <= 19'd215040;
      swing_r  <= 19'd153600;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FEEDBACK: fbg_r    <= cfg_wdata[9:0];
        REG_MIX:      mix_r    <= cfg_wdata[10:0];
        REG_DEPTH:    depth_r  <= cfg_wdata[10:0];
        REG_STEP:     step_r   <= cfg_wdata[24:0];
        REG_OFFSET:   offset_r <= cfg_wdata[15:0];
        REG_CENTER:   center_r <= cfg_wdata[18:0];
        REG_SWING:    swing_r  <= cfg_wdata[18:0];
        default: ;
      endcase
    end
  end

  logic [10:0] depth_c;
  logic [10:0] mix_c;
  assign depth_c = (depth_r > 11'd1024) ? 11'd1024 : depth_r;
  assign mix_c   = (mix_r > 11'd1024) ? 11'd1024 : mix_r;

  // quarter-wave sine table
  logic [15:0] qtab [QN+1];
  for (genvar g = 0; g <= QN; g++) begin : g_qtab
    assign qtab[g] = quarter_entry(g, SW);
  end

  // control and data state
  logic [3:0]           state_r, state_nxt;
  logic                 ch_r, ch_nxt;
  logic                 clr_r, clr_nxt;
  logic [AW-1:0]        clr_idx_r;
  logic [AW-1:0]        w_r, w_nxt;
  logic [31:0]          phase_r, phase_nxt;
  logic signed [SB-1:0] fb_l_r, fb_r_r;
  logic signed [SB-1:0] in_l_r, in_r_r;
  logic signed [SB-1:0] res_l_r;
  logic [TDW-1:0]       out_data_r;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [MB-1:0] sine_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] acc_r;
  logic [DW-1:0]        delay_r;
  logic [7:0]           f_r;
  logic signed [SB-1:0] wet_r;

  logic signed [SB-1:0] in_c, fb_c;
  assign in_c = ch_r ? in_r_r : in_l_r;
  assign fb_c = ch_r ? fb_r_r : fb_l_r;

  // sine lookup
  logic [31:0]   ph_c;
  logic [SW-1:0] sidx;
  logic [1:0]    quad;
  logic [SW-3:0] qm;
  logic [SW-2:0] qi;
  logic [15:0]   smag;
  assign ph_c = ch_r ? (phase_r + {offset_r, 16'd0}) : phase_r;
  assign sidx = ph_c[31 -: SW];
  assign quad = sidx[SW-1:SW-2];
  assign qm   = sidx[SW-3:0];
  assign qi   = quad[0] ? ((SW-1)'(QN) - {1'b0, qm}) : {1'b0, qm};
  assign smag = qtab[qi];

  // write value
  logic signed [SB:0]   wsum;
  logic signed [SB-1:0] wval;
  localparam logic signed [SB:0] SMAX = (SB+1)'((64'd1 << (SB-1)) - 64'd1);
  localparam logic signed [SB:0] SMIN = -SMAX - (SB+1)'(1);
  assign wsum = (SB+1)'(in_c) + (SB+1)'(fb_c);
  always_comb begin
    if (wsum > SMAX) wval = SMAX[SB-1:0];
    else if (wsum < SMIN) wval = SMIN[SB-1:0];
    else wval = wsum[SB-1:0];
  end

  // shared multiplier
  logic signed [SB-1:0] rda, rdb;
  logic signed [MA-1:0] op_a;
  logic signed [MB-1:0] op_b;
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_M1: begin
        op_a = MA'(depth_c);
        op_b = sine_r;
      end
      ST_M2: begin
        op_a = MA'(swing_r);
        op_b = prod_r[26:10];
      end
      ST_I1: begin
        op_a = MA'(rda);
        op_b = MB'(9'd256 - {1'b0, f_r});
      end
      ST_I2: begin
        op_a = MA'(rdb);
        op_b = MB'(f_r);
      end
      ST_FB: begin
        op_a = MA'(wet_r);
        op_b = MB'(fbg_r);
      end
      ST_M5: begin
        op_a = MA'(in_c);
        op_b = MB'(11'd1024 - mix_c);
      end
      ST_M6: begin
        op_a = MA'(wet_r);
        op_b = MB'(mix_c);
      end
      default: ;
    endcase
  end

  // delay and read position
  logic signed [DLW-1:0] dsum;
  logic [DW-1:0]         dclamp;
  assign dsum = DLW'($signed({1'b0, center_r})) + DLW'($signed(prod_r[35:15]));
  always_comb begin
    if (dsum < DLW'(256)) dclamp = DW'(256);
    else if (dsum > DLW'(DHI)) dclamp = DW'(DHI);
    else dclamp = dsum[DW-1:0];
  end

  logic [RPW-1:0] rp0, rp;
  logic [AW-1:0]  ri, rj;
  assign rp0 = RPW'({w_r, 8'd0}) + RPW'(SPAN) - RPW'(delay_r);
  assign rp  = (rp0 >= RPW'(SPAN)) ? (rp0 - RPW'(SPAN)) : rp0;
  assign ri  = rp[AW+7:8];
  assign rj  = (ri == AW'(BUFFER_DEPTH - 1)) ? '0 : ri + AW'(1);

  // mix output
  logic signed [PW-1:0]    osum;
  logic signed [PW-11:0]   oshift;
  logic signed [SB-1:0]    oval;
  assign osum   = acc_r + prod_r;
  assign oshift = osum[PW-1:10];
  always_comb begin
    if (oshift > (PW-10)'(SMAX)) oval = SMAX[SB-1:0];
    else if (oshift < (PW-10)'(SMIN)) oval = SMIN[SB-1:0];
    else oval = oshift[SB-1:0];
  end

  // delay lines
  line_ctl_t            ctl_l, ctl_r;
  logic [AW-1:0]        wa;
  logic signed [SB-1:0] wd;
  logic signed [SB-1:0] rda_l, rdb_l, rda_r, rdb_r;
  assign wa = clr_r ? clr_idx_r : w_r;
  assign wd = clr_r ? '0 : wval;
  assign ctl_l.wr_en = clr_r || (state_r == ST_SIN && !ch_r);
  assign ctl_r.wr_en = clr_r || (state_r == ST_SIN && ch_r);
  assign ctl_l.rd_en = (state_r == ST_ADDR) && !ch_r;
  assign ctl_r.rd_en = (state_r == ST_ADDR) && ch_r;
  assign rda = ch_r ? rda_r : rda_l;
  assign rdb = ch_r ? rdb_r : rdb_l;

  scfd_line #(.DEPTH(BUFFER_DEPTH), .AW(AW), .SB(SB)) u_line_l (
    .clk       (clk),
    .ctl       (ctl_l),
    .wr_addr   (wa),
    .wr_data   (wd),
    .rd_addr_a (ri),
    .rd_addr_b (rj),
    .rd_data_a (rda_l),
    .rd_data_b (rdb_l)
  );

  scfd_line #(.DEPTH(BUFFER_DEPTH), .AW(AW), .SB(SB)) u_line_r (
    .clk       (clk),
    .ctl       (ctl_r),
    .wr_addr   (wa),
    .wr_data   (wd),
    .rd_addr_a (ri),
    .rd_addr_b (rj),
    .rd_data_a (rda_r),
    .rd_data_b (rdb_r)
  );

  // sequencer
  logic in_acc;
  logic launch;
  assign in_tready = (state_r == ST_IDLE) && !clr_r;
  assign in_acc    = in_tvalid && in_tready;
  assign launch    = (state_r == ST_OUT) && ch_r && !(out_valid_r && !out_tready);

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    w_nxt         = w_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    clr_nxt       = clr_r && (clr_idx_r != AW'(BUFFER_DEPTH - 1));
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SIN;
          ch_nxt    = 1'b0;
        end
      end
      ST_SIN:  state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_DLY;
      ST_DLY:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_I1;
      ST_I1:   state_nxt = ST_I2;
      ST_I2:   state_nxt = ST_I3;
      ST_I3:   state_nxt = ST_FB;
      ST_FB:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_M6;
      ST_M6:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = ST_SIN;
        end else if (launch) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          w_nxt         = (w_r == AW'(BUFFER_DEPTH - 1)) ? '0 : w_r + AW'(1);
          phase_nxt     = phase_r + 32'(step_r);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= 1'b0;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      w_r         <= '0;
      phase_r     <= '0;
      fb_l_r      <= '0;
      fb_r_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      clr_r       <= clr_nxt;
      clr_idx_r   <= clr_idx_r + AW'(1);
      w_r         <= w_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_M5) begin
        if (ch_r) fb_r_r <= prod_r[SB+9:10];
        else fb_l_r <= prod_r[SB+9:10];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // product holds in the last step so a stalled result stays intact
    if (state_r != ST_OUT) prod_r <= PW'(op_a) * PW'(op_b);
    if (in_acc) begin
      in_l_r <= in_tdata[SB-1:0];
      in_r_r <= in_tdata[2*SB-1:SB];
    end
    if (state_r == ST_SIN) begin
      sine_r <= quad[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    end
    if (state_r == ST_DLY) delay_r <= dclamp;
    if (state_r == ST_ADDR) f_r <= rp[7:0];
    if (state_r == ST_I2 || state_r == ST_M6) acc_r <= prod_r;
    if (state_r == ST_I3) wet_r <= osum[SB+7:8];
    if (state_r == ST_OUT && !ch_r) res_l_r <= oval;
    if (launch) out_data_r <= TDW'({oval, res_l_r});
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SCFD_ASSERT_NOW(a_ready_not_clearing, in_tready, !clr_r)
  `SCFD_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, state_r == ST_SIN && !ch_r)
  `SCFD_ASSERT_NEXT(a_result_held, out_tvalid && !out_tready, out_tvalid)
  `SCFD_ASSERT_NEXT(a_data_held, out_tvalid && !out_tready, $stable(out_tdata))
  `SCFD_ASSERT_NOW(a_no_write_in_flight, state_r != ST_IDLE, !clr_r)

endmodule

>>> rtl/scfd_line.sv
module scfd_line
  import scfd_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int SB    = 24
) (
  input  logic                 clk,
  input  line_ctl_t            ctl,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [SB-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr_a,
  input  logic [AW-1:0]        rd_addr_b,
  output logic signed [SB-1:0] rd_data_a,
  output logic signed [SB-1:0] rd_data_b
);

  logic signed [SB-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> bench/stereo_chorus_feedback_delay_test.sv
module stereo_chorus_feedback_delay_test;
  import scfd_pkg::*;

  localparam int DEPTH = 2048;
  localparam int ENTRIES = 1024;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [23:0] right;
    logic signed [23:0] left;
  } pair_t;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    bit known;
    logic signed [23:0] exp_left;
    logic signed [23:0] exp_right;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [24:0] cfg_wdata = '0;

  stereo_chorus_feedback_delay uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  int sine_q15 [ENTRIES];
  longint left_line [DEPTH];
  longint right_line [DEPTH];
  int unsigned wr_ptr;
  bit [31:0] phase_acc;
  longint left_fb, right_fb;
  int unsigned fb_gain, mix_gain, depth_gain, step_inc, offset_frac, center_q8, swing_q8;

  pair_t expected_pairs[$];
  int errors = 0;

  function automatic longint fshift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clip24(longint x);
    return x > 8388607 ? 8388607 : (x < -8388608 ? -8388608 : x);
  endfunction

  function automatic longint unsigned qsin(longint unsigned a);
    longint unsigned a2, t;
    a2 = (a * a) >> 30;
    t = 64'd1073741824 - a2 / 110;
    t = 64'd1073741824 - ((a2 * t) >> 30) / 72;
    t = 64'd1073741824 - ((a2 * t) >> 30) / 42;
    t = 64'd1073741824 - ((a2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((a2 * t) >> 30) / 6;
    return (a * t) >> 30;
  endfunction

  task automatic chorus_reset();
    longint unsigned p, quad, r, s, v;
    for (int k = 0; k < ENTRIES; k++) begin
      p = (longint'(k) << 32) / ENTRIES;
      quad = (p >> 30) & 3;
      r = p & 64'h3FFF_FFFF;
      if (quad[0]) r = 64'd1073741824 - r;
      s = qsin((r * 64'd1686629713) >> 30);
      v = (s * 32767 + (64'd1 << 29)) >> 30;
      sine_q15[k] = quad >= 2 ? -int'(v) : int'(v);
    end
    for (int k = 0; k < DEPTH; k++) begin
      left_line[k] = 0;
      right_line[k] = 0;
    end
    wr_ptr = 0; phase_acc = 0; left_fb = 0; right_fb = 0;
    fb_gain = 512; mix_gain = 512; depth_gain = 512; step_inc = 44739;
    offset_frac = 0; center_q8 = 215040; swing_q8 = 153600;
  endtask

  function automatic longint chorus_channel(ref longint line [DEPTH], ref longint fb,
                                            input longint x, input bit [31:0] ph);
    int unsigned dep, mx, idx, i, j, f;
    longint lfo, dly, rp, wet;
    dep = depth_gain > 1024 ? 1024 : depth_gain;
    mx = mix_gain > 1024 ? 1024 : mix_gain;
    idx = ph >> 22;
    line[wr_ptr] = clip24(x + fb);
    lfo = fshift(longint'(sine_q15[idx]) * dep, 10);
    dly = longint'(center_q8) + fshift(longint'(swing_q8) * lfo, 15);
    if (dly < 256) dly = 256;
    if (dly > (DEPTH - 2) * 256) dly = (DEPTH - 2) * 256;
    rp = longint'(wr_ptr) * 256 + DEPTH * 256 - dly;
    if (rp >= DEPTH * 256) rp -= DEPTH * 256;
    i = 32'(rp >> 8);
    f = 32'(rp & 255);
    j = (i + 1) % DEPTH;
    wet = fshift(longint'(256 - f) * line[i] + longint'(f) * line[j], 8);
    fb = fshift(longint'(fb_gain) * wet, 10);
    return clip24(fshift(x * (1024 - mx) + wet * mx, 10));
  endfunction

  function automatic pair_t chorus_step(pair_t d);
    pair_t o;
    bit [31:0] rph;
    rph = phase_acc + (offset_frac << 16);
    o.left = 24'(chorus_channel(left_line, left_fb, longint'(d.left), phase_acc));
    o.right = 24'(chorus_channel(right_line, right_fb, longint'(d.right), rph));
    wr_ptr = (wr_ptr + 1) % DEPTH;
    phase_acc += step_inc;
    return o;
  endfunction

  task automatic write_reg(logic [2:0] addr, logic [24:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_addr <= addr; cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (addr)
      REG_FEEDBACK: fb_gain = 32'(val[9:0]);
      REG_MIX: mix_gain = 32'(val[10:0]);
      REG_DEPTH: depth_gain = 32'(val[10:0]);
      REG_STEP: step_inc = 32'(val);
      REG_OFFSET: offset_frac = 32'(val[15:0]);
      REG_CENTER: center_q8 = 32'(val[18:0]);
      REG_SWING: swing_q8 = 32'(val[18:0]);
      default: ;
    endcase
  endtask

  // called at a falling edge
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_pair(pair_t d, bit pause);
    if (pause) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_pairs.push_back(chorus_step(d));
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_block(int n);
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      pair_t d;
      d.left = rand_sample();
      d.right = rand_sample();
      if (burst == 0) burst = $urandom_range(1, 30);
      send_pair(d, burst == 1 && $urandom_range(0, 1));
      burst--;
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_tready <= ($urandom_range(0, 2) == 0);
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pair_t got, want;
      got = out_tdata;
      if (expected_pairs.size() == 0) begin
        $error("unexpected beat %h", out_tdata);
        errors++;
      end else begin
        want = expected_pairs.pop_front();
        if (got.left !== want.left) begin
          $error("left_out expected %0d actual %0d", want.left, got.left);
          errors++;
        end
        if (got.right !== want.right) begin
          $error("right_out expected %0d actual %0d", want.right, got.right);
          errors++;
        end
      end
    end
  end

  row_t rows [12];

  initial begin
    #50_000_000;
    $display("** stereo_chorus_feedback_delay: FAILED **");
    $finish;
  end

  initial begin
    chorus_reset();
    rows[0] = '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0};
    rows[1] = '{24'sh7FFFFF, 24'sh800000, 1'b1, 24'sd4194303, -24'sd4194304};
    rows[2] = '{24'sh800000, 24'sh7FFFFF, 1'b1, -24'sd4194304, 24'sd4194303};
    rows[3] = '{24'sd1000, -24'sd1000, 1'b1, 24'sd500, -24'sd500};
    rows[4] = '{-24'sd1, 24'sd1, 1'b1, -24'sd1, 24'sd0};
    for (int k = 5; k < 12; k++)
      rows[k] = '{24'(k * 1234567), 24'(-k * 765431), 1'b0, 24'sd0, 24'sd0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[k]) begin
      pair_t d;
      d.left = rows[k].left;
      d.right = rows[k].right;
      send_pair(d, 1'b0);
      if (rows[k].known) begin
        pair_t w;
        w = expected_pairs[$];
        if (w.left !== rows[k].exp_left || w.right !== rows[k].exp_right) begin
          $error("row %0d left_out/right_out expected %0d/%0d actual %0d/%0d", k,
                 rows[k].exp_left, rows[k].exp_right, w.left, w.right);
          errors++;
        end
      end
    end
    drain();
    // extremes and unused index
    write_reg(REG_FEEDBACK, 25'd1003);
    write_reg(REG_MIX, 25'd2047);
    write_reg(REG_DEPTH, 25'd2047);
    write_reg(REG_STEP, 25'd16777216);
    write_reg(REG_OFFSET, 25'd65535);
    write_reg(REG_CENTER, 25'd524287);
    write_reg(REG_SWING, 25'd524287);
    write_reg(REG_UNUSED, 25'h1FFFFFF);
    random_block(300);
    drain();
    write_reg(REG_FEEDBACK, 25'd1023);
    write_reg(REG_MIX, 25'd0);
    write_reg(REG_DEPTH, 25'd0);
    write_reg(REG_STEP, 25'd0);
    write_reg(REG_OFFSET, 25'd0);
    write_reg(REG_CENTER, 25'd0);
    write_reg(REG_SWING, 25'd0);
    random_block(300);
    drain();
    write_reg(REG_MIX, 25'd1024);
    write_reg(REG_DEPTH, 25'd1024);
    write_reg(REG_STEP, 25'h1FFFFFF);
    write_reg(REG_CENTER, 25'd1000);
    write_reg(REG_SWING, 25'd300000);
    random_block(300);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_FEEDBACK, 25'($urandom_range(0, 1023)));
      write_reg(REG_MIX, 25'($urandom_range(0, 2047)));
      write_reg(REG_DEPTH, 25'($urandom_range(0, 2047)));
      write_reg(REG_STEP, 25'($urandom_range(0, 2000000)));
      write_reg(REG_OFFSET, 25'($urandom_range(0, 65535)));
      write_reg(REG_CENTER, 25'($urandom_range(0, 524287)));
      write_reg(REG_SWING, 25'($urandom_range(0, 524287)));
      random_block(350);
      drain();
    end
    if (errors == 0)
      $display("** stereo_chorus_feedback_delay: PASSED **");
    else
      $display("** stereo_chorus_feedback_delay: FAILED **");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/scfd_pkg.sv
rtl/scfd_line.sv
rtl/stereo_chorus_feedback_delay.sv
bench/stereo_chorus_feedback_delay_test.sv
